// ===== sv/pdrm_pkg.sv =====
// ----------------------------------------------------------------------------
// pdrm_pkg
// shared constants of the descriptor ring manager
// ----------------------------------------------------------------------------
`default_nettype none

package pdrm_pkg;

  localparam int unsigned RingDepthDef = 1024;
  localparam int unsigned ChannelsDef  = 2;

  localparam int unsigned CmdW = 3;
  localparam int unsigned StW  = 2;
  localparam int unsigned LenW = 16;
  localparam int unsigned TimW = 64;
  localparam int unsigned HdlW = 32;
  localparam int unsigned RxcW = 10;

  localparam logic [CmdW-1:0] CMD_PUT   = 3'd0;
  localparam logic [CmdW-1:0] CMD_PEEK  = 3'd1;
  localparam logic [CmdW-1:0] CMD_SWAP  = 3'd2;
  localparam logic [CmdW-1:0] CMD_GET   = 3'd3;
  localparam logic [CmdW-1:0] CMD_CLEAN = 3'd4;
  localparam logic [CmdW-1:0] CMD_FLUSH = 3'd5;

  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StW-1:0] ST_ERR   = 2'd2;

  localparam logic [1:0] RING_FREE = 2'd0;
  localparam logic [1:0] RING_RX   = 2'd1;
  localparam logic [1:0] RING_TX   = 2'd2;
  localparam logic [1:0] RING_DONE = 2'd3;

endpackage

`default_nettype wire

// ===== sv/pdrm_ram.sv =====
// ----------------------------------------------------------------------------
// pdrm_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pdrm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== sv/packet_descriptor_ring_manager.sv =====
// ----------------------------------------------------------------------------
// packet_descriptor_ring_manager
// per-channel descriptor pool moving through free, rx, tx and done rings
// ----------------------------------------------------------------------------
// One command transaction enters on the in channel (valid_i / stall_o) and
// exactly one result transaction leaves on the out channel (valid_o /
// stall_i). Ring heads and tails sit in flip-flops; ring entries and the
// slot descriptors sit in synchronous single-port memories.
// A command that moves or reports a slot shows its result after these
// steps: read the ring entry, read or fill the slot descriptor, write the
// slot number into the destination ring when it moves. A command rejected
// at decode shows its result in the next cycle. The block works on one
// command at a time and takes the next one in the cycle after the result
// is taken.
// After reset a clearing pass writes the free ring of every channel,
// one entry per cycle; no command is accepted until it ends. A stalled
// result holds in the output register and no new command is taken until
// it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_descriptor_ring_manager
  import pdrm_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDef,
  parameter int unsigned CHANNELS   = ChannelsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 stall_o,
  input  wire logic [CmdW-1:0] command_i,
  input  wire logic            channel_i,
  input  wire logic [LenW-1:0] pkt_length_i,
  input  wire logic [TimW-1:0] time_usec_i,
  input  wire logic [HdlW-1:0] buf_handle_i,
  output logic                 valid_o,
  input  wire logic            stall_i,
  output logic [StW-1:0]       status_o,
  output logic [LenW-1:0]      out_length_o,
  output logic [TimW-1:0]      out_time_o,
  output logic [HdlW-1:0]      out_handle_o,
  output logic [RxcW-1:0]      rx_count_o
);

  localparam int unsigned PW    = $clog2(RING_DEPTH);
  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned NR    = CHANNELS * 4;
  localparam int unsigned RW    = $clog2(NR);
  localparam int unsigned RAW   = RW + PW;
  localparam int unsigned SAW   = CW + PW;
  localparam int unsigned SDW   = LenW + TimW + HdlW;
  localparam int unsigned ClrN  = CHANNELS * (1 << PW);
  localparam logic [PW-1:0] PMax = PW'(RING_DEPTH - 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_SLT  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [PW-1:0] head_q [NR];
  logic [PW-1:0] tail_q [NR];

  logic [SAW:0] clr_q;

  // latched command
  logic [CmdW-1:0] cmd_q;
  logic [CW-1:0]   ch_q;
  logic [LenW-1:0] len_q;
  logic [TimW-1:0] tim_q;
  logic [HdlW-1:0] hdl_q;
  logic [RW-1:0]   src_q, dst_q;
  logic            rep_q, mv_q;

  logic [StW-1:0]  st_q;
  logic [LenW-1:0] olen_q;
  logic [TimW-1:0] otim_q;
  logic [HdlW-1:0] ohdl_q;
  logic [RxcW-1:0] rxc_q;
  logic            ovld_q;

  // ring memory
  logic           r_we;
  logic [RAW-1:0] r_addr;
  logic [PW-1:0]  r_wd, r_rd;
  // slot memory
  logic           s_we;
  logic [SAW-1:0] s_addr;
  logic [SDW-1:0] s_wd, s_rd;

  pdrm_ram #(.Width(PW), .Depth(1 << RAW)) u_ring (
    .clk_i, .we_i(r_we), .addr_i(r_addr), .wdata_i(r_wd), .rdata_o(r_rd)
  );
  pdrm_ram #(.Width(SDW), .Depth(1 << SAW)) u_slot (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wd), .rdata_o(s_rd)
  );

  function automatic logic [PW-1:0] cnt(input logic [PW-1:0] h, input logic [PW-1:0] t);
    logic [PW:0] d;
    begin
      d = {1'b0, h} - {1'b0, t};
      if (d[PW]) d = d + (PW+1)'(RING_DEPTH);
      cnt = d[PW-1:0];
    end
  endfunction

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    inc = (p == PMax) ? '0 : p + PW'(1);
  endfunction

  logic accept, out_take, ch_ok;
  assign out_take = ovld_q && !stall_i;
  assign stall_o  = (state_q != S_IDLE);
  assign accept   = valid_i && !stall_o;
  assign ch_ok    = (32'(channel_i) < CHANNELS);

  // decode of the incoming command against current ring pointers
  logic [CW-1:0] ch_in;
  logic [RW-1:0] rfr, rrx, rtx, rdn;
  logic [PW-1:0] cfr, crx, ctx, cdn;
  logic [StW-1:0] dst_st;
  logic [RW-1:0]  d_src, d_dst;
  logic           d_mv, d_rep;

  assign ch_in = CW'(channel_i);
  assign rfr = RW'({ch_in, RING_FREE});
  assign rrx = RW'({ch_in, RING_RX});
  assign rtx = RW'({ch_in, RING_TX});
  assign rdn = RW'({ch_in, RING_DONE});
  assign cfr = cnt(head_q[rfr], tail_q[rfr]);
  assign crx = cnt(head_q[rrx], tail_q[rrx]);
  assign ctx = cnt(head_q[rtx], tail_q[rtx]);
  assign cdn = cnt(head_q[rdn], tail_q[rdn]);

  always_comb begin
    dst_st = ST_OK;
    d_src  = rfr;
    d_dst  = rrx;
    d_mv   = 1'b0;
    d_rep  = 1'b0;
    if (!ch_ok) begin
      dst_st = ST_ERR;
    end else begin
      unique case (command_i)
        CMD_PUT: begin
          d_src = rfr; d_dst = rrx;
          if (cfr == '0 || crx == PMax) dst_st = ST_ERR;
          else d_mv = 1'b1;
        end
        CMD_PEEK: begin
          d_src = rrx; d_dst = rrx;
          if (crx == '0) dst_st = ST_EMPTY;
          else d_rep = 1'b1;
        end
        CMD_SWAP: begin
          d_src = rrx; d_dst = rtx;
          if (crx == '0 || ctx == PMax) dst_st = ST_ERR;
          else d_mv = 1'b1;
        end
        CMD_GET: begin
          d_src = rtx; d_dst = rdn;
          if (ctx == '0) dst_st = ST_EMPTY;
          else if (cdn == PMax) dst_st = ST_ERR;
          else begin d_mv = 1'b1; d_rep = 1'b1; end
        end
        CMD_CLEAN: begin
          d_src = rdn; d_dst = rfr;
          if (cdn == '0) dst_st = ST_EMPTY;
          else if (cfr == PMax) dst_st = ST_ERR;
          else begin d_mv = 1'b1; d_rep = 1'b1; end
        end
        CMD_FLUSH: begin
          d_dst = rfr;
          if (crx != '0) d_src = rrx;
          else if (ctx != '0) d_src = rtx;
          else d_src = rdn;
          if (crx == '0 && ctx == '0 && cdn == '0) dst_st = ST_EMPTY;
          else if (cfr == PMax) dst_st = ST_ERR;
          else begin d_mv = 1'b1; d_rep = 1'b1; end
        end
        default: dst_st = ST_ERR;
      endcase
    end
  end

  // slot number read from the source ring
  logic [PW-1:0] slot_q;
  logic [RW-1:0] rx_idx;
  assign rx_idx = RW'({ch_q, RING_RX});

  always_comb begin
    state_d = state_q;
    r_we   = 1'b0;
    r_addr = {src_q, tail_q[src_q]};
    r_wd   = slot_q;
    s_we   = 1'b0;
    s_addr = {ch_q, slot_q};
    s_wd   = {len_q, tim_q, hdl_q};
    unique case (state_q)
      S_CLR: begin
        r_we   = 1'b1;
        r_addr = RAW'({clr_q[SAW-1:PW], RING_FREE, clr_q[PW-1:0]});
        r_wd   = clr_q[PW-1:0];
        if (32'(clr_q) == ClrN - 1) state_d = S_IDLE;
      end
      S_IDLE: if (accept) state_d = (d_mv || d_rep) ? S_RD : S_OUT;
      S_RD:   state_d = S_SLT;
      S_SLT: begin
        s_addr = {ch_q, r_rd};
        if (cmd_q == CMD_PUT) s_we = 1'b1;
        state_d = S_WB;
      end
      S_WB: begin
        if (mv_q) begin
          r_we   = 1'b1;
          r_addr = {dst_q, head_q[dst_q]};
        end
        state_d = S_OUT;
      end
      S_OUT:  if (out_take) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // rx count is taken after pointer updates, so pick the post-update value
  logic [RW-1:0] rxn;
  logic          rx_ok_n;
  logic [PW-1:0] rx_h_n, rx_t_n;
  always_comb begin
    rxn     = (state_q == S_IDLE) ? rrx : rx_idx;
    rx_ok_n = (state_q == S_IDLE) ? ch_ok : 1'b1;
    rx_h_n  = head_q[rxn];
    rx_t_n  = tail_q[rxn];
    // pointer values in S_WB: apply this cycle's move for the count
    if (state_q == S_WB && mv_q) begin
      if (dst_q == rxn) rx_h_n = inc(head_q[rxn]);
      if (src_q == rxn) rx_t_n = inc(tail_q[rxn]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      ovld_q  <= 1'b0;
      for (int i = 0; i < NR; i++) begin
        head_q[i] <= (i % 4 == 0) ? PMax : '0;
        tail_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (state_q == S_WB && mv_q) begin
        tail_q[src_q] <= inc(tail_q[src_q]);
        head_q[dst_q] <= inc(head_q[dst_q]);
      end
      if (state_d == S_OUT && state_q != S_OUT) ovld_q <= 1'b1;
      else if (out_take) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      ch_q  <= ch_in;
      len_q <= pkt_length_i;
      tim_q <= time_usec_i;
      hdl_q <= buf_handle_i;
      src_q <= d_src;
      dst_q <= d_dst;
      mv_q  <= d_mv;
      rep_q <= d_rep;
      st_q  <= dst_st;
      olen_q <= '0;
      otim_q <= '0;
      ohdl_q <= '0;
    end
    if (state_q == S_SLT) slot_q <= r_rd;
    if (state_q == S_WB) begin
      if (rep_q) {olen_q, otim_q, ohdl_q} <= s_rd;
    end
    if (state_d == S_OUT && state_q != S_OUT) begin
      rxc_q <= rx_ok_n ? RxcW'(cnt(rx_h_n, rx_t_n)) : '0;
    end
  end

  assign valid_o      = ovld_q;
  assign status_o     = st_q;
  assign out_length_o = olen_q;
  assign out_time_o   = otim_q;
  assign out_handle_o = ohdl_q;
  assign rx_count_o   = rxc_q;

  // a result is never shown while a command is still being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (state_q == S_OUT))
    else $error("result valid outside output state");
  // no command is taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o)
    else $error("input open while result pending");
  // a held result keeps its status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> $stable(status_o))
    else $error("stalled status changed");

endmodule

`default_nettype wire
